/* hdl/bncf_pkg.sv */
// Package for the 3x3 binary neighbor count filter.
// Holds sizes, register codes, window masks and the structs passed between the modules.
// No dependencies.
`default_nettype none

package bncf_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 10;
  localparam int THR_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
  localparam int POS_W   = ((DIM_W > COL_W) ? ((DIM_W > ROW_W) ? DIM_W : ROW_W)
                                            : ((COL_W > ROW_W) ? COL_W : ROW_W)) + 1;
  localparam int SCORE_W = 8;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [PIX_W-1:0]   FG_VALUE     = 8'd255;
  localparam logic [PIX_W-1:0]   BG_VALUE     = 8'd0;
  localparam logic [SCORE_W-1:0] CENTER_SCORE = 8'd200;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd3;
  localparam logic [DIM_W-1:0] WIDTH_RESET     = 10'd64;
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = 10'd13;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_t;

  // Window layout: three columns of three bits, oldest column in bits 2:0.
  // Within a column bit 0 is the upper row, bit 1 the middle, bit 2 the lower.
  localparam int         WIN_W       = 9;
  localparam int         CENTER_BIT  = 4;
  localparam logic [8:0] MASK_LEFT   = 9'h007;
  localparam logic [8:0] MASK_RIGHT  = 9'h1C0;
  localparam logic [8:0] MASK_TOP    = 9'h049;
  localparam logic [8:0] MASK_BOTTOM = 9'h124;

  typedef struct packed {
    logic upper;
    logic middle;
  } line_entry_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             cur;
    logic             have;
    logic             ccol_first;
    logic             ccol_last;
    logic             crow_first;
    logic             crow_last;
    logic             last;
  } pos_info_t;

endpackage

`default_nettype wire

/* hdl/bncf_pos.sv */
// Raster position tracking for the neighbor count filter.
// Works out the center position and border flags of each incoming pixel.
// Depends on bncf_pkg.
`default_nettype none

module bncf_pos (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic                         restart,
  input  wire logic [bncf_pkg::PIX_W-1:0]   pixel_in,
  input  wire logic                         flush,
  input  wire logic [bncf_pkg::DIM_W-1:0]   image_width,
  input  wire logic [bncf_pkg::DIM_W-1:0]   image_height,
  output bncf_pkg::pos_info_t               info
);

  logic [bncf_pkg::COL_W-1:0] col_count, col_count_next;
  logic [bncf_pkg::ROW_W-1:0] row_count, row_count_next;
  logic [bncf_pkg::POS_W-1:0] w, h, col, row, ccol, crow, col_inc;
  logic                       wrap;

  always_comb begin
    w = bncf_pkg::POS_W'(image_width);
    if (w == '0) begin
      w = bncf_pkg::POS_W'(1);
    end else if (w > bncf_pkg::POS_W'(bncf_pkg::MAX_WIDTH)) begin
      w = bncf_pkg::POS_W'(bncf_pkg::MAX_WIDTH);
    end
    h = bncf_pkg::POS_W'(image_height);
    if (h == '0) begin
      h = bncf_pkg::POS_W'(1);
    end else if (h > bncf_pkg::POS_W'(bncf_pkg::MAX_HEIGHT)) begin
      h = bncf_pkg::POS_W'(bncf_pkg::MAX_HEIGHT);
    end

    wrap = (bncf_pkg::POS_W'(col_count) >= w) || (bncf_pkg::POS_W'(row_count) > h + 1'b1);
    col  = wrap ? '0 : bncf_pkg::POS_W'(col_count);
    row  = wrap ? '0 : bncf_pkg::POS_W'(row_count);

    // The center lags the input by one row plus one pixel.
    if (col != '0) begin
      info.have = (row != '0);
      crow      = row - 1'b1;
      ccol      = col - 1'b1;
    end else begin
      info.have = (row >= bncf_pkg::POS_W'(2));
      crow      = row - bncf_pkg::POS_W'(2);
      ccol      = w - 1'b1;
    end

    info.col        = col[bncf_pkg::COL_W-1:0];
    info.cur        = !flush && (row < h) && (pixel_in == bncf_pkg::FG_VALUE);
    info.ccol_first = (ccol == '0);
    info.ccol_last  = (ccol == w - 1'b1);
    info.crow_first = (crow == '0);
    info.crow_last  = (crow == h - 1'b1);
    info.last       = info.have && info.ccol_last && info.crow_last;

    col_inc        = col + 1'b1;
    col_count_next = col_count;
    row_count_next = row_count;
    if (restart) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if (accept) begin
      if (info.last) begin
        col_count_next = '0;
        row_count_next = '0;
      end else if (col_inc >= w) begin
        col_count_next = '0;
        row_count_next = bncf_pkg::ROW_W'(row + 1'b1);
      end else begin
        col_count_next = col_inc[bncf_pkg::COL_W-1:0];
        row_count_next = row[bncf_pkg::ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/bncf_linebuf.sv */
// Two-row line buffer of foreground bits, one entry per column.
// Registered read with a bypass for a write to the same column in the same cycle.
// Depends on bncf_pkg.
`default_nettype none

module bncf_linebuf (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rd_en,
  input  wire logic [bncf_pkg::COL_W-1:0]   rd_addr,
  input  wire logic                         wr_en,
  input  wire logic [bncf_pkg::COL_W-1:0]   wr_addr,
  input  bncf_pkg::line_entry_t             wr_data,
  output logic                              top,
  output logic                              mid
);

  bncf_pkg::line_entry_t mem [bncf_pkg::MAX_WIDTH];
  bncf_pkg::line_entry_t rd_data;
  bncf_pkg::line_entry_t byp_data;
  bncf_pkg::line_entry_t entry;
  logic                  bypass;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else if (rd_en) begin
      bypass <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_comb begin
    entry = bypass ? byp_data : rd_data;
    top   = entry.upper;
    mid   = entry.middle;
  end

endmodule

`default_nettype wire

/* hdl/bncf_win.sv */
// Window stage of the neighbor count filter: holds the item read from the line
// buffer, shifts the 3x3 window, scores it and keeps the result register.
// Depends on bncf_pkg.
`default_nettype none

module bncf_win (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  bncf_pkg::pos_info_t               info,
  input  wire logic                         top,
  input  wire logic                         mid,
  input  wire logic [bncf_pkg::THR_W-1:0]   threshold,
  input  wire logic                         out_ready,
  output logic                              in_ready,
  output logic                              out_valid,
  output logic [bncf_pkg::PIX_W-1:0]        pixel_out,
  output logic                              last_of_frame,
  output logic                              wr_en,
  output logic [bncf_pkg::COL_W-1:0]        wr_addr,
  output bncf_pkg::line_entry_t             wr_data
);

  logic                            s1_valid;
  bncf_pkg::pos_info_t             s1;
  logic [bncf_pkg::WIN_W-1:0]      window, window_next, masked;
  logic                            s1_adv;
  logic [3:0]                      count;
  logic [bncf_pkg::SCORE_W-1:0]    score;

  assign s1_adv   = s1_valid && (!s1.have || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  // The line buffer entry for this column is rewritten while the item sits here.
  assign wr_en          = s1_valid;
  assign wr_addr        = s1.col;
  assign wr_data.upper  = mid;
  assign wr_data.middle = s1.cur;

  always_comb begin
    window_next = {s1.cur, mid, top, window[bncf_pkg::WIN_W-1:3]};
    masked      = window_next;
    if (s1.ccol_first) masked = masked & ~bncf_pkg::MASK_LEFT;
    if (s1.ccol_last)  masked = masked & ~bncf_pkg::MASK_RIGHT;
    if (s1.crow_first) masked = masked & ~bncf_pkg::MASK_TOP;
    if (s1.crow_last)  masked = masked & ~bncf_pkg::MASK_BOTTOM;

    count = '0;
    for (int i = 0; i < bncf_pkg::WIN_W; i++) begin
      if (i != bncf_pkg::CENTER_BIT) begin
        count = count + 4'(masked[i]);
      end
    end
    score = bncf_pkg::SCORE_W'(count);
    if (masked[bncf_pkg::CENTER_BIT]) begin
      score = bncf_pkg::CENTER_SCORE + bncf_pkg::SCORE_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      window    <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        window <= window_next;
      end
      if (s1_adv && s1.have) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= info;
    end
    if (s1_adv && s1.have) begin
      pixel_out     <= (score >= threshold) ? bncf_pkg::FG_VALUE : bncf_pkg::BG_VALUE;
      last_of_frame <= s1.last;
    end
  end

endmodule

`default_nettype wire

/* hdl/binary_neighbor_count_fill_3x3_unit.sv */
// Top level of the 3x3 binary neighbor count filter with its register port.
// Depends on bncf_pkg, bncf_pos, bncf_linebuf and bncf_win.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   pixel_in[7:0], flush
//   output    out_valid / out_ready pixel_out[7:0], last_of_frame
//   config    psel, penable, pready paddr[3:0], pwrite, pwdata[31:0], prdata[31:0]
//
// One pixel per clock is accepted while the output is not stalled; the result for a center is
// registered in the window stage and then the result register after the pixel that completes its
// window, one row plus one pixel behind the input. The line buffer's single read port and the
// window stage set that rate. Reset loads the register defaults and clears the position
// counters; the line buffer needs no clearing, as rows read before they are written fall
// outside the frame. A stalled output holds its result while one more pixel can still enter.
`default_nettype none

module binary_neighbor_count_fill_3x3_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bncf_pkg::PIX_W-1:0]    pixel_in,
  input  wire logic                          flush,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bncf_pkg::PIX_W-1:0]         pixel_out,
  output logic                               last_of_frame,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bncf_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bncf_pkg::DATA_W-1:0]   pwdata,
  output logic [bncf_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  logic [bncf_pkg::THR_W-1:0] threshold;
  logic [bncf_pkg::DIM_W-1:0] image_width;
  logic [bncf_pkg::DIM_W-1:0] image_height;
  bncf_pkg::reg_idx_t         reg_idx;
  logic                       cfg_wr, restart, in_accept;
  bncf_pkg::pos_info_t        info;
  logic                       top, mid, wr_en;
  logic [bncf_pkg::COL_W-1:0] wr_addr;
  bncf_pkg::line_entry_t      wr_data;

  assign pready    = 1'b1;
  assign reg_idx   = bncf_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign restart   = cfg_wr && (reg_idx == bncf_pkg::REG_WIDTH || reg_idx == bncf_pkg::REG_HEIGHT);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= bncf_pkg::THRESHOLD_RESET;
      image_width  <= bncf_pkg::WIDTH_RESET;
      image_height <= bncf_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        bncf_pkg::REG_THRESHOLD: threshold    <= pwdata[bncf_pkg::THR_W-1:0];
        bncf_pkg::REG_WIDTH:     image_width  <= pwdata[bncf_pkg::DIM_W-1:0];
        bncf_pkg::REG_HEIGHT:    image_height <= pwdata[bncf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bncf_pkg::REG_THRESHOLD: prdata = bncf_pkg::DATA_W'(threshold);
      bncf_pkg::REG_WIDTH:     prdata = bncf_pkg::DATA_W'(image_width);
      bncf_pkg::REG_HEIGHT:    prdata = bncf_pkg::DATA_W'(image_height);
      default:                 prdata = '0;
    endcase
  end

  bncf_pos u_pos (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .restart      (restart),
    .pixel_in     (pixel_in),
    .flush        (flush),
    .image_width  (image_width),
    .image_height (image_height),
    .info         (info)
  );

  bncf_linebuf u_linebuf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (info.col),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .top     (top),
    .mid     (mid)
  );

  bncf_win u_win (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .info          (info),
    .top           (top),
    .mid           (mid),
    .threshold     (threshold),
    .out_ready     (out_ready),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

endmodule

`default_nettype wire

/* hdl/bncf_checker.sv */
// Port-level checks for the neighbor count filter, bound to its top level.
// Depends on bncf_pkg.
`default_nettype none

module bncf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bncf_pkg::PIX_W-1:0]    pixel_out,
  input wire logic                          last_of_frame,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [bncf_pkg::ADDR_W-1:0]   paddr,
  input wire logic [bncf_pkg::DATA_W-1:0]   pwdata,
  input wire logic [bncf_pkg::DATA_W-1:0]   prdata,
  input wire logic                          pready
);

  logic width_sel;
  logic width_wr;
  assign width_sel = (bncf_pkg::reg_idx_t'(paddr[3:2]) == bncf_pkg::REG_WIDTH);
  assign width_wr  = psel && penable && pwrite && pready && width_sel;

  // A result waiting for the sink keeps its transaction unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_of_frame))
    else $error("output transaction changed while stalled");

  // Results are always binary.
  a_out_binary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_out == bncf_pkg::FG_VALUE || pixel_out == bncf_pkg::BG_VALUE))
    else $error("output pixel is neither 0 nor 255");

  // With the result register empty the block can always take a pixel.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled although no result is waiting");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  // The width register reads back what was written.
  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    width_wr ##1 width_sel |->
      prdata == bncf_pkg::DATA_W'($past(pwdata[bncf_pkg::DIM_W-1:0])))
    else $error("width register readback mismatch");

endmodule

bind binary_neighbor_count_fill_3x3_unit bncf_checker u_bncf_checker (.*);

`default_nettype wire

/* tb/binary_neighbor_count_fill_3x3_unit_tb.sv */
// Testbench for the 3x3 binary neighbor count filter: drives pixel transactions and
// register writes, predicts every filtered pixel and checks the output stream in order.
// Depends on bncf_pkg and binary_neighbor_count_fill_3x3_unit.
module binary_neighbor_count_fill_3x3_unit_tb;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SELF_WEIGHT   = 200;
  localparam int SPARE_INDEX   = 3;
  localparam logic [bncf_pkg::ADDR_W-1:0] SPARE_ADDR = bncf_pkg::ADDR_W'(SPARE_INDEX * 4);

  // Window cells: three columns of three bits, oldest column in bits 2:0,
  // and within a column bit 0 is the upper row.
  localparam logic [8:0] LEFT_COLUMN  = 9'h007;
  localparam logic [8:0] RIGHT_COLUMN = 9'h1C0;
  localparam logic [8:0] TOP_ROW      = 9'h049;
  localparam logic [8:0] BOTTOM_ROW   = 9'h124;
  localparam logic [8:0] CENTER_CELL  = 9'h010;

  typedef struct packed {
    logic [bncf_pkg::PIX_W-1:0] value;
    logic                       last;
  } filtered_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [bncf_pkg::PIX_W-1:0]  pixel_in = '0;
  logic                        flush = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [bncf_pkg::PIX_W-1:0]  pixel_out;
  logic                        last_of_frame;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [bncf_pkg::ADDR_W-1:0] paddr = '0;
  logic [bncf_pkg::DATA_W-1:0] pwdata = '0;
  logic [bncf_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  // Predictor state: configuration, two line stores, window and raster position.
  logic [bncf_pkg::THR_W-1:0] cfg_threshold = 8'd3;
  logic [bncf_pkg::DIM_W-1:0] cfg_width     = 10'd64;
  logic [bncf_pkg::DIM_W-1:0] cfg_height    = 10'd13;
  bit                         two_rows_up [bncf_pkg::MAX_WIDTH];
  bit                         one_row_up [bncf_pkg::MAX_WIDTH];
  logic [8:0]                 window = '0;
  int unsigned                next_col = 0;
  int unsigned                next_row = 0;

  filtered_t expected_pixels[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        pixels_sent = 0;
  int        mismatch_count = 0;
  int        idle_cycles = 0;

  binary_neighbor_count_fill_3x3_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH %0t: %s", $time, msg);
  endtask

  function automatic int unsigned bounded_dim(input logic [bncf_pkg::DIM_W-1:0] v,
                                              input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void predict_filtered_pixel(input logic [bncf_pkg::PIX_W-1:0] pix,
                                                 input logic fl);
    int unsigned w, h, col, row, ccol, score;
    int          crow;
    logic        cur, top, mid, have;
    logic [8:0]  win;
    filtered_t   res;
    w = bounded_dim(cfg_width, bncf_pkg::MAX_WIDTH);
    h = bounded_dim(cfg_height, bncf_pkg::MAX_HEIGHT);
    col = next_col;
    row = next_row;
    if (col >= w || row > h + 1) begin
      col = 0;
      row = 0;
    end
    // Pixels in the two padding rows below the frame count as background.
    cur = !fl && row < h && pix == bncf_pkg::FG_VALUE;
    top = two_rows_up[col];
    mid = one_row_up[col];
    two_rows_up[col] = mid;
    one_row_up[col] = cur;
    window = {cur, mid, top, window[8:3]};
    if (col >= 1) begin
      have = row >= 1;
      crow = int'(row) - 1;
      ccol = col - 1;
    end else begin
      have = row >= 2;
      crow = int'(row) - 2;
      ccol = w - 1;
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
    next_col = col;
    next_row = row;
    if (!have) return;
    win = window;
    if (ccol == 0) win &= ~LEFT_COLUMN;
    if (ccol == w - 1) win &= ~RIGHT_COLUMN;
    if (crow == 0) win &= ~TOP_ROW;
    if (crow == int'(h) - 1) win &= ~BOTTOM_ROW;
    score = (|(win & CENTER_CELL)) ? SELF_WEIGHT : 0;
    score += $countones(win & ~CENTER_CELL);
    res.value = (score >= cfg_threshold) ? bncf_pkg::FG_VALUE : bncf_pkg::BG_VALUE;
    res.last = crow == int'(h) - 1 && ccol == w - 1;
    if (res.last) begin
      next_col = 0;
      next_row = 0;
    end
    expected_pixels.push_back(res);
  endfunction

  always @(posedge clk) begin
    filtered_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %0d last %0b", pixel_out, last_of_frame));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_out !== want.value)
          report_mismatch($sformatf("pixel_out %0d, expected %0d", pixel_out, want.value));
        if (last_of_frame !== want.last)
          report_mismatch($sformatf("last_of_frame %0b, expected %0b", last_of_frame, want.last));
      end
    end
  end

  // Ends the run when no transaction of any kind has happened for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("binary_neighbor_count_fill_3x3_unit test failed");
      $finish;
    end
  end

  function automatic logic [bncf_pkg::ADDR_W-1:0] reg_addr(input bncf_pkg::reg_idx_t r);
    return bncf_pkg::ADDR_W'(4 * r);
  endfunction

  task automatic apb_write(input logic [bncf_pkg::ADDR_W-1:0] addr,
                           input logic [bncf_pkg::DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (addr >> 2)
      bncf_pkg::REG_THRESHOLD: cfg_threshold = data[bncf_pkg::THR_W-1:0];
      bncf_pkg::REG_WIDTH: begin
        cfg_width = data[bncf_pkg::DIM_W-1:0];
        next_col = 0;
        next_row = 0;
      end
      bncf_pkg::REG_HEIGHT: begin
        cfg_height = data[bncf_pkg::DIM_W-1:0];
        next_col = 0;
        next_row = 0;
      end
      default: ;
    endcase
  endtask

  task automatic apb_read_check(input bncf_pkg::reg_idx_t r,
                                input logic [bncf_pkg::DATA_W-1:0] want);
    logic [bncf_pkg::DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= reg_addr(r);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      report_mismatch($sformatf("register %s read %0d, expected %0d", r.name(), got, want));
  endtask

  task automatic check_registers();
    apb_read_check(bncf_pkg::REG_THRESHOLD, bncf_pkg::DATA_W'(cfg_threshold));
    apb_read_check(bncf_pkg::REG_WIDTH, bncf_pkg::DATA_W'(cfg_width));
    apb_read_check(bncf_pkg::REG_HEIGHT, bncf_pkg::DATA_W'(cfg_height));
  endtask

  // Bits above each register's width carry junk, which the block must drop.
  task automatic program_filter(input int thr, input int w, input int h);
    apb_write(reg_addr(bncf_pkg::REG_THRESHOLD),
              (bncf_pkg::DATA_W'($urandom) << bncf_pkg::THR_W) | bncf_pkg::DATA_W'(thr));
    apb_write(reg_addr(bncf_pkg::REG_WIDTH),
              (bncf_pkg::DATA_W'($urandom) << bncf_pkg::DIM_W) | bncf_pkg::DATA_W'(w));
    apb_write(reg_addr(bncf_pkg::REG_HEIGHT),
              (bncf_pkg::DATA_W'($urandom) << bncf_pkg::DIM_W) | bncf_pkg::DATA_W'(h));
    check_registers();
  endtask

  task automatic send_pixel(input logic [bncf_pkg::PIX_W-1:0] pix, input logic fl);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    flush <= fl;
    do @(posedge clk); while (!in_ready);
    predict_filtered_pixel(pix, fl);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    else if (pick < 90) send_pixel(bncf_pkg::PIX_W'($urandom_range(255)), 1'b0);
    else send_pixel(bncf_pkg::PIX_W'($urandom_range(255)), 1'b1);
  endtask

  // A whole frame plus the row and pixel of padding that drain it; a broken
  // frame stops at a random point.
  task automatic run_frame(input int w, input int h, input bit broken);
    int total, stop_at;
    total = w * h + w + 1;
    stop_at = broken ? $urandom_range(total - 1, 1) : total;
    for (int i = 0; i < stop_at; i++) begin
      if (i < w * h) send_random_pixel();
      else if ($urandom_range(3) == 0) send_pixel(bncf_pkg::PIX_W'($urandom_range(255)), 1'b0);
      else send_pixel(bncf_pkg::PIX_W'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(4))
      0, 1: return $urandom_range(9);
      2: return $urandom_range(212, 196);
      3: return $urandom_range(255);
      default: return $urandom_range(1) ? 255 : 0;
    endcase
  endfunction

  task automatic test_reset_values();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    check_registers();
    repeat (120) send_random_pixel();
    settle();
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    program_filter(201, 3, 3);
    // A write past the last register must leave all three settings and the position alone.
    apb_write(SPARE_ADDR, $urandom);
    send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    send_pixel(bncf_pkg::BG_VALUE, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    send_pixel(bncf_pkg::FG_VALUE, 1'b1);
    send_pixel(8'd127, 1'b0);
    send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    send_pixel(8'd128, 1'b0);
    // Pixels below the last row only pad the frame.
    send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    send_pixel(bncf_pkg::BG_VALUE, 1'b1);
    send_pixel(bncf_pkg::FG_VALUE, 1'b1);
    settle();
    program_filter(0, 1, 1);
    send_pixel(bncf_pkg::BG_VALUE, 1'b0);
    send_pixel(bncf_pkg::BG_VALUE, 1'b1);
    send_pixel(bncf_pkg::FG_VALUE, 1'b1);
    settle();
    program_filter(255, 1, 1);
    send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    send_pixel(bncf_pkg::BG_VALUE, 1'b1);
    settle();
    // Zero width and height are taken as one.
    program_filter(200, 0, 0);
    send_pixel(bncf_pkg::FG_VALUE, 1'b0);
    send_pixel(bncf_pkg::BG_VALUE, 1'b1);
    send_pixel(bncf_pkg::BG_VALUE, 1'b1);
    settle();
  endtask

  task automatic test_small_frames(input int send_pct, input int stall_pct, input int budget);
    int start_count, w, h;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    start_count = pixels_sent;
    while (pixels_sent - start_count < budget) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      h = $urandom_range(8, 1);
      program_filter(pick_threshold(), w, h);
      repeat ($urandom_range(3, 1)) run_frame(w, h, $urandom_range(9) == 0);
      settle();
    end
  endtask

  task automatic test_widest_row();
    send_idle_pct = 20;
    recv_stall_pct = 20;
    // Out-of-range width and height are clamped to the largest and smallest sizes.
    program_filter(pick_threshold(), 1023, 0);
    run_frame(bncf_pkg::MAX_WIDTH, 1, 1'b0);
    settle();
  endtask

  task automatic test_tallest_column();
    send_idle_pct = 54;
    recv_stall_pct = 0;
    program_filter(pick_threshold(), 1, bncf_pkg::MAX_HEIGHT);
    repeat (60) send_random_pixel();
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_cases();
    test_small_frames(0, 0, 50);
    test_small_frames(54, 0, 50);
    test_small_frames(0, 54, 50);
    test_small_frames(20, 20, 50);
    test_widest_row();
    test_tallest_column();
    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixels never came out", expected_pixels.size()));
    if (mismatch_count == 0) begin
      $display("binary_neighbor_count_fill_3x3_unit test passed");
    end else begin
      $display("binary_neighbor_count_fill_3x3_unit test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bncf_pkg.sv
hdl/bncf_pos.sv
hdl/bncf_linebuf.sv
hdl/bncf_win.sv
hdl/binary_neighbor_count_fill_3x3_unit.sv
hdl/bncf_checker.sv
tb/binary_neighbor_count_fill_3x3_unit_tb.sv
